// ===== rtl/tcl_pkg.sv =====
// Shared codes and constants for the thermal current limiter.
`timescale 1ns / 1ps

package tcl_pkg;

  // Input item operation codes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_GEAR = 1'b1;

  // Mode classes
  localparam logic [1:0] MODE_ORDINARY = 2'd0;
  localparam logic [1:0] MODE_BOOST    = 2'd1;
  localparam logic [1:0] MODE_FLASH    = 2'd2;
  localparam logic [1:0] MODE_SPARE    = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] REG_TARGET_TEMP       = 3'd0;
  localparam logic [2:0] REG_TURBO_TARGET_TEMP = 3'd1;
  localparam logic [2:0] REG_RELEASE_TEMP      = 3'd2;
  localparam logic [2:0] REG_TURBO_OFF_TEMP    = 3'd3;
  localparam logic [2:0] REG_SHUTDOWN_TEMP     = 3'd4;
  localparam logic [2:0] REG_MIN_CURRENT       = 3'd5;
  localparam logic [2:0] REG_TURBO_CURRENT     = 3'd6;

  // Register reset values
  localparam logic signed [7:0] RST_TARGET_TEMP       = 8'sd55;
  localparam logic signed [7:0] RST_TURBO_TARGET_TEMP = 8'sd60;
  localparam logic signed [7:0] RST_RELEASE_TEMP      = 8'sd45;
  localparam logic signed [7:0] RST_TURBO_OFF_TEMP    = 8'sd70;
  localparam logic signed [7:0] RST_SHUTDOWN_TEMP     = 8'sd80;
  localparam logic [14:0]       RST_MIN_CURRENT       = 15'd300;
  localparam logic [14:0]       RST_TURBO_CURRENT     = 15'd20000;

  // Loop constants
  localparam int CUR_STEP     = 2300;  // mA per step of proportional gain
  localparam int CUR_MAX      = 32767;
  localparam int GAIN_STEPS   = CUR_MAX / CUR_STEP;
  localparam int GAIN_W       = $clog2(GAIN_STEPS + 2);
  localparam int HOT_GAIN     = 5;
  localparam int HOT_MARGIN   = 5;
  localparam int FLAG_MARGIN  = 10;
  localparam int ERR_DEADBAND = 2;
  localparam logic [7:0] ERR_MASK = 8'h7E;
  localparam logic [5:0] HOLD_SHORT = 6'd24;
  localparam logic [5:0] HOLD_LONG  = 6'd60;

  // Integral scaling, a power of two
  localparam int INTEGRAL_DIVISOR = 16;

  typedef logic signed [9:0] temp_w_t;

endpackage

// ===== rtl/thermal_current_limiter_top.sv =====
// Thermal current limiter: input register, single-pass PI update, result register.
`timescale 1ns / 1ps

// Thermal throttle for an LED driver, one item per control tick. A tick item
// updates the hysteresis flags (turbo block, turbo leave, overheat, limiter
// enable; skipped when sensor_ok is low), runs the PI loop on the temperature
// error and returns the limited current, never below min_current while the
// limiter is active. A gear-change item rebases the proportional offset when
// the gear needs stepdown and returns a zero limit with the stored flags.
// Each item waits in the input register and is evaluated in one pass of
// combinational logic into the result register, which updates the loop
// state at the same edge. One item is taken every cycle while results
// drain. The rate is set by the single evaluation pass; while a finished
// result waits for out_ready the input register holds at most one more
// item, then in_ready drops.
// Configuration registers are written through cfg_we/cfg_index/cfg_data and
// must only change while no item is in flight.
module thermal_current_limiter_top import tcl_pkg::*; #(
  parameter int INTEGRAL_LIMIT = 256
) (
  input  logic               clk,
  input  logic               rst,
  // configuration write port
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [14:0]        cfg_data,
  // input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               operation,
  input  logic signed [7:0]  temperature,
  input  logic               sensor_ok,
  input  logic               needs_stepdown,
  input  logic [1:0]         mode_class,
  input  logic               converter_on,
  input  logic [14:0]        requested_current,
  input  logic [14:0]        output_current,
  input  logic [14:0]        previous_current,
  input  logic [14:0]        new_gear_current,
  // output channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic [14:0]        current_limit,
  output logic               step_down_active,
  output logic               limiter_enabled,
  output logic               turbo_disabled,
  output logic               leave_turbo,
  output logic               overheat_fault,
  output logic               sensor_fault
);

  localparam int ICW = $clog2(INTEGRAL_LIMIT + 1) + 1;
  localparam logic signed [ICW-1:0] ILIM = ICW'(INTEGRAL_LIMIT);

  // Configuration registers
  logic signed [7:0] target_temp;
  logic signed [7:0] turbo_target_temp;
  logic signed [7:0] release_temp;
  logic signed [7:0] turbo_off_temp;
  logic signed [7:0] shutdown_temp;
  logic [14:0]       min_current;
  logic [14:0]       turbo_current;

  // Loop state
  logic signed [15:0]    prop_offset;
  logic signed [ICW-1:0] integral_count;
  logic [5:0]            raise_lock_timer;
  logic                  step_down_flag;
  logic                  limiter_flag;
  logic                  shutdown_flag;
  logic                  turbo_block_flag;
  logic                  turbo_leave_flag;

  // Input register
  logic              inq_valid;
  logic              inq_op;
  logic signed [7:0] inq_temp;
  logic              inq_sok;
  logic              inq_needs;
  logic [1:0]        inq_mode;
  logic              inq_conv;
  logic [14:0]       inq_req;
  logic [14:0]       inq_outc;
  logic [14:0]       inq_prev;
  logic [14:0]       inq_gear;

  logic fire;

  // Evaluation results
  logic signed [17:0]    prop_offset_next;
  logic signed [ICW-1:0] integral_count_next;
  logic [5:0]            raise_lock_timer_next;
  logic                  step_down_flag_next;
  logic                  limiter_flag_next;
  logic                  shutdown_flag_next;
  logic                  turbo_block_flag_next;
  logic                  turbo_leave_flag_next;
  logic signed [17:0]    limit;
  logic                  sfault;

  // Datapath helpers
  temp_w_t             temp_w;
  temp_w_t             goal_w;
  temp_w_t             err_up;
  temp_w_t             err_dn;
  logic [GAIN_W-1:0]   gain_q;
  logic [GAIN_W-1:0]   gain_f1;
  logic [6:0]          gain_f;
  logic [14:0]         prop_step;
  logic signed [17:0]  bound;
  logic signed [17:0]  cut;
  logic signed [17:0]  req_w;
  logic signed [17:0]  min_w;
  logic signed [16:0]  gear_diff;
  logic                lim_hyst;

  function automatic logic hyst(input logic cur, input temp_w_t t,
                                input temp_w_t hi, input temp_w_t lo);
    logic r;
    r = cur;
    if (t > hi) begin
      r = 1'b1;
    end else if (t < lo) begin
      r = 1'b0;
    end
    return r;
  endfunction

  // Handshake: advance the input register whenever its item moves on
  assign fire     = inq_valid && (!out_valid || out_ready);
  assign in_ready = !inq_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_temp       <= RST_TARGET_TEMP;
      turbo_target_temp <= RST_TURBO_TARGET_TEMP;
      release_temp      <= RST_RELEASE_TEMP;
      turbo_off_temp    <= RST_TURBO_OFF_TEMP;
      shutdown_temp     <= RST_SHUTDOWN_TEMP;
      min_current       <= RST_MIN_CURRENT;
      turbo_current     <= RST_TURBO_CURRENT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TARGET_TEMP:       target_temp       <= $signed(cfg_data[7:0]);
        REG_TURBO_TARGET_TEMP: turbo_target_temp <= $signed(cfg_data[7:0]);
        REG_RELEASE_TEMP:      release_temp      <= $signed(cfg_data[7:0]);
        REG_TURBO_OFF_TEMP:    turbo_off_temp    <= $signed(cfg_data[7:0]);
        REG_SHUTDOWN_TEMP:     shutdown_temp     <= $signed(cfg_data[7:0]);
        REG_MIN_CURRENT:       min_current       <= cfg_data;
        REG_TURBO_CURRENT:     turbo_current     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register: hold the item until its evaluation fires
  always_ff @(posedge clk) begin
    if (rst) begin
      inq_valid <= 1'b0;
    end else if (in_ready) begin
      inq_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      inq_op    <= operation;
      inq_temp  <= temperature;
      inq_sok   <= sensor_ok;
      inq_needs <= needs_stepdown;
      inq_mode  <= mode_class;
      inq_conv  <= converter_on;
      inq_req   <= requested_current;
      inq_outc  <= output_current;
      inq_prev  <= previous_current;
      inq_gear  <= new_gear_current;
    end
  end

  // Proportional gain step: output current divided by the step size
  always_comb begin
    gain_q = '0;
    for (int k = 1; k <= GAIN_STEPS; k++) begin
      if (inq_outc >= 15'(k * CUR_STEP)) begin
        gain_q = GAIN_W'(k);
      end
    end
  end

  // Single evaluation pass: flags, PI update, limit
  always_comb begin
    prop_offset_next      = 18'(prop_offset);
    integral_count_next   = integral_count;
    raise_lock_timer_next = raise_lock_timer;
    step_down_flag_next   = step_down_flag;
    limiter_flag_next     = limiter_flag;
    shutdown_flag_next    = shutdown_flag;
    turbo_block_flag_next = turbo_block_flag;
    turbo_leave_flag_next = turbo_leave_flag;
    limit                 = '0;
    sfault                = 1'b0;

    temp_w    = 10'(inq_temp);
    goal_w    = (inq_mode == MODE_BOOST) ? 10'(turbo_target_temp) : 10'(target_temp);
    err_up    = temp_w - goal_w;
    err_dn    = goal_w - temp_w;
    gain_f1   = gain_q + GAIN_W'(1);
    gain_f    = (temp_w > 10'(turbo_off_temp) - 10'(HOT_MARGIN)) ?
                7'(gain_f1) * 7'(HOT_GAIN) : 7'(gain_f1);
    prop_step = 15'(gain_f) * 15'(err_up[7:0]);
    bound     = $signed({3'b000, turbo_current}) - $signed({3'b000, min_current});
    req_w     = $signed({3'b000, inq_req});
    min_w     = $signed({3'b000, min_current});
    gear_diff = $signed({2'b00, inq_gear}) - $signed({2'b00, inq_prev});
    lim_hyst  = hyst(limiter_flag, temp_w, goal_w, 10'(release_temp));
    cut       = '0;

    if (inq_op == OP_GEAR) begin
      // Rebase the offset to the step from the previous current to the new gear, floored at zero
      if (inq_needs) begin
        prop_offset_next    = (gear_diff < 0) ? 18'sd0 : 18'(gear_diff);
        integral_count_next = '0;
      end
    end else begin
      if (!inq_sok) begin
        sfault = 1'b1;
      end else begin
        turbo_leave_flag_next = hyst(turbo_leave_flag, temp_w,
                                     10'(shutdown_temp) - 10'(FLAG_MARGIN),
                                     10'(turbo_off_temp) - 10'(FLAG_MARGIN));
        turbo_block_flag_next = hyst(turbo_block_flag, temp_w, 10'(turbo_off_temp),
                                     10'(turbo_off_temp) - 10'(FLAG_MARGIN));
        shutdown_flag_next    = hyst(shutdown_flag, temp_w, 10'(shutdown_temp),
                                     10'(target_temp) - 10'(FLAG_MARGIN));
        if (!inq_needs) begin
          limiter_flag_next = 1'b0;
        end else if (lim_hyst) begin
          limiter_flag_next = 1'b1;
        end else if (prop_offset == 16'sd0 && integral_count < 0) begin
          limiter_flag_next = 1'b0;
        end
      end

      if (!limiter_flag_next) begin
        integral_count_next = '0;
        prop_offset_next    = '0;
      end else if (inq_conv || inq_mode == MODE_FLASH) begin
        if (temp_w > goal_w) begin
          raise_lock_timer_next = HOLD_SHORT;
          if (err_up > 10'(ERR_DEADBAND)) begin
            prop_offset_next = 18'(prop_offset) + $signed({3'b000, prop_step});
            if (prop_offset_next > bound) begin
              prop_offset_next = bound;
            end
            raise_lock_timer_next = HOLD_LONG;
          end
          if (integral_count < ILIM) begin
            integral_count_next = integral_count + ICW'(1);
          end
        end else if (temp_w < goal_w) begin
          if (raise_lock_timer != 6'd0) begin
            raise_lock_timer_next = raise_lock_timer - 6'd1;
          end else begin
            if ((err_dn[7:0] & ERR_MASK) != 8'd0) begin
              prop_offset_next = prop_offset_next - 18'(err_dn);
            end
            if (prop_offset_next < 0) begin
              prop_offset_next = '0;
            end
          end
          if (integral_count > -ILIM) begin
            integral_count_next = integral_count - ICW'(1);
          end
        end
      end

      if (!limiter_flag_next) begin
        limit = req_w;
      end else begin
        cut = prop_offset_next + 18'(integral_count_next / INTEGRAL_DIVISOR);
        if (cut < 0) begin
          cut = '0;
        end
        limit = req_w - cut;
        if (limit < min_w) begin
          // Floor at the minimum and rebase the offset to match
          prop_offset_next    = req_w - min_w;
          integral_count_next = '0;
          limit               = min_w;
        end
      end
      step_down_flag_next = (limit != req_w);
    end
  end

  // Commit loop state with each evaluated item
  always_ff @(posedge clk) begin
    if (rst) begin
      prop_offset      <= '0;
      integral_count   <= '0;
      raise_lock_timer <= '0;
      step_down_flag   <= 1'b0;
      limiter_flag     <= 1'b0;
      shutdown_flag    <= 1'b0;
      turbo_block_flag <= 1'b0;
      turbo_leave_flag <= 1'b0;
    end else if (fire) begin
      prop_offset      <= prop_offset_next[15:0];
      integral_count   <= integral_count_next;
      raise_lock_timer <= raise_lock_timer_next;
      step_down_flag   <= step_down_flag_next;
      limiter_flag     <= limiter_flag_next;
      shutdown_flag    <= shutdown_flag_next;
      turbo_block_flag <= turbo_block_flag_next;
      turbo_leave_flag <= turbo_leave_flag_next;
    end
  end

  // Result register: load on fire, drop after the output transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      current_limit    <= limit[14:0];
      step_down_active <= step_down_flag_next;
      limiter_enabled  <= limiter_flag_next;
      turbo_disabled   <= turbo_block_flag_next;
      leave_turbo      <= turbo_leave_flag_next;
      overheat_fault   <= shutdown_flag_next;
      sensor_fault     <= sfault;
    end
  end

  // Integral counter stays inside its clamp
  a_integral_range: assert property (@(posedge clk) disable iff (rst)
    integral_count <= ILIM && integral_count >= -ILIM)
    else $error("integral counter outside its clamp");

  // Hold-off timer never loads above its long value
  a_timer_range: assert property (@(posedge clk) disable iff (rst)
    raise_lock_timer <= HOLD_LONG)
    else $error("raise hold-off timer out of range");

  // An evaluated item always reaches the result register
  a_fire_result: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid)
    else $error("evaluated item did not produce a result");

  // No step-down can be reported while the limiter is off
  a_stepdown_needs_limiter: assert property (@(posedge clk) disable iff (rst)
    out_valid && !limiter_enabled |-> !step_down_active)
    else $error("step-down reported with limiter disabled");

endmodule

// ===== tb/sv/tb_thermal_current_limiter_top.sv =====
// Self-checking testbench for the thermal current limiter top level.
`timescale 1ns / 1ps

module tb_thermal_current_limiter_top import tcl_pkg::*; ();

  // Run shape
  localparam int HALF_NS           = 2;
  localparam int RAND_PER_PHASE    = 242;
  localparam int NUM_PHASES        = 8;
  localparam int RX_HOLDOFF_CYCLES = 200;
  localparam int SETTLE_CYCLES     = 6;
  localparam int DRAIN_GUARD       = 5000;
  localparam int LIMIT_NS          = 2_000_000;

  // Loop constants of the limiter, kept locally for the predictor
  localparam int INT_LIMIT    = 256;
  localparam int INT_DIV      = 16;
  localparam int STEP_MA      = 2300;
  localparam int SHORT_HOLD_T = 24;
  localparam int LONG_HOLD_T  = 60;
  localparam int HOT_MUL      = 5;
  localparam int HOT_MARGIN_C = 5;
  localparam int FLAG_BAND    = 10;
  localparam int DEADBAND     = 2;
  localparam int ERR_BITS     = 'h7E;

  typedef struct packed {
    logic              op;
    logic signed [7:0] temp;
    logic              sok;
    logic              needs;
    logic [1:0]        mode;
    logic              conv;
    logic [14:0]       req;
    logic [14:0]       outc;
    logic [14:0]       prev;
    logic [14:0]       gear;
  } tick_item_t;

  typedef struct packed {
    logic [14:0] limit;
    logic        step_down;
    logic        limiter;
    logic        turbo_blk;
    logic        turbo_leave;
    logic        overheat;
    logic        sfault;
  } limit_result_t;

  typedef struct packed {
    tick_item_t    item;
    logic          typed;
    limit_result_t want;
  } dir_row_t;

  // DUT signals
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [14:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        operation = OP_TICK;
  logic signed [7:0] temperature = '0;
  logic        sensor_ok = 1'b0;
  logic        needs_stepdown = 1'b0;
  logic [1:0]  mode_class = MODE_ORDINARY;
  logic        converter_on = 1'b0;
  logic [14:0] requested_current = '0;
  logic [14:0] output_current = '0;
  logic [14:0] previous_current = '0;
  logic [14:0] new_gear_current = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [14:0] current_limit;
  logic        step_down_active;
  logic        limiter_enabled;
  logic        turbo_disabled;
  logic        leave_turbo;
  logic        overheat_fault;
  logic        sensor_fault;

  // Predictor copy of the configuration
  int tgt_norm  = RST_TARGET_TEMP;
  int tgt_turbo = RST_TURBO_TARGET_TEMP;
  int rel_t     = RST_RELEASE_TEMP;
  int off_t     = RST_TURBO_OFF_TEMP;
  int shut_t    = RST_SHUTDOWN_TEMP;
  int min_c     = RST_MIN_CURRENT;
  int turbo_c   = RST_TURBO_CURRENT;

  // Predictor copy of the loop state
  int p_off    = 0;
  int i_cnt    = 0;
  int hold_cnt = 0;
  bit f_step, f_lim, f_shut, f_block, f_leave;

  // Expected results in transfer order, plus run bookkeeping
  limit_result_t limits_due[$];
  dir_row_t      dir_rows[$];
  int  err_count    = 0;
  int  result_idx   = 0;
  int  walk_temp    = 25;
  int  holdoff_req  = 0;
  int  holdoff_done = 0;
  bit  quiet        = 1'b0;

  always #(HALF_NS) clk = ~clk;

  thermal_current_limiter_top #(
    .INTEGRAL_LIMIT(INT_LIMIT)
  ) u_top (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .operation         (operation),
    .temperature       (temperature),
    .sensor_ok         (sensor_ok),
    .needs_stepdown    (needs_stepdown),
    .mode_class        (mode_class),
    .converter_on      (converter_on),
    .requested_current (requested_current),
    .output_current    (output_current),
    .previous_current  (previous_current),
    .new_gear_current  (new_gear_current),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .current_limit     (current_limit),
    .step_down_active  (step_down_active),
    .limiter_enabled   (limiter_enabled),
    .turbo_disabled    (turbo_disabled),
    .leave_turbo       (leave_turbo),
    .overheat_fault    (overheat_fault),
    .sensor_fault      (sensor_fault)
  );

  // Print one mismatch line and count it.
  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic check_field(string name, logic [14:0] got, logic [14:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d field %s got %0d want %0d",
                                result_idx, name, got, want));
  endtask

  // Schmitt trigger: set above hi, clear below lo, hold in between.
  function automatic bit trip_hyst(bit cur, int t, int hi, int lo);
    if (t > hi) return 1'b1;
    if (t < lo) return 1'b0;
    return cur;
  endfunction

  function automatic int clamp_temp(int t);
    if (t > 127) return 127;
    if (t < -128) return -128;
    return t;
  endfunction

  // Advance the predicted loop state by one item and return its result.
  function automatic limit_result_t predict_limit(tick_item_t it);
    int t, goal, err, gain, bound, cut, lim, req, outc;
    limit_result_t r;
    t    = $signed(it.temp);
    req  = it.req;
    outc = it.outc;
    goal = (it.mode == MODE_BOOST) ? tgt_turbo : tgt_norm;
    lim  = 0;
    r    = '0;
    if (it.op == OP_GEAR) begin
      // rebase only for gears under thermal control
      if (it.needs) begin
        p_off = int'(it.gear) - int'(it.prev);
        if (p_off < 0) p_off = 0;
        i_cnt = 0;
      end
    end else begin
      // flags, skipped on a bad sensor reading
      if (!it.sok) begin
        r.sfault = 1'b1;
      end else begin
        f_leave = trip_hyst(f_leave, t, shut_t - FLAG_BAND, off_t - FLAG_BAND);
        f_block = trip_hyst(f_block, t, off_t, off_t - FLAG_BAND);
        f_shut  = trip_hyst(f_shut, t, shut_t, tgt_norm - FLAG_BAND);
        if (!it.needs) begin
          f_lim = 1'b0;
        end else if (trip_hyst(f_lim, t, goal, rel_t)) begin
          f_lim = 1'b1;
        end else if (p_off == 0 && i_cnt < 0) begin
          f_lim = 1'b0;
        end
      end
      // PI loop, only with the converter running or in strobe
      if (!f_lim) begin
        i_cnt = 0;
        p_off = 0;
      end else if (it.conv || it.mode == MODE_FLASH) begin
        if (t > goal) begin
          err = t - goal;
          hold_cnt = SHORT_HOLD_T;
          if (err > DEADBAND) begin
            gain  = outc / STEP_MA + 1;
            bound = turbo_c - min_c;
            if (t > off_t - HOT_MARGIN_C) gain = gain * HOT_MUL;
            p_off = p_off + gain * err;
            if (p_off > bound) p_off = bound;
            hold_cnt = LONG_HOLD_T;
          end
          if (i_cnt < INT_LIMIT) i_cnt = i_cnt + 1;
        end else if (t < goal) begin
          err = goal - t;
          if (hold_cnt != 0) begin
            hold_cnt = hold_cnt - 1;
          end else begin
            if ((err & ERR_BITS) != 0) p_off = p_off - err;
            if (p_off < 0) p_off = 0;
          end
          if (i_cnt > -INT_LIMIT) i_cnt = i_cnt - 1;
        end
      end
      // limit, floored at min_current while the limiter is on
      if (!f_lim) begin
        lim = req;
      end else begin
        cut = p_off + i_cnt / INT_DIV;
        if (cut < 0) cut = 0;
        lim = req - cut;
        if (lim < min_c) begin
          p_off = req - min_c;
          i_cnt = 0;
          lim = min_c;
        end
      end
      f_step = (lim != req);
    end
    r.limit       = lim[14:0];
    r.step_down   = f_step;
    r.limiter     = f_lim;
    r.turbo_blk   = f_block;
    r.turbo_leave = f_leave;
    r.overheat    = f_shut;
    return r;
  endfunction

  function automatic tick_item_t mk_item(logic op, int temp, bit sok, bit needs,
                                         logic [1:0] mode, bit conv, int req,
                                         int outc, int prev, int gear);
    tick_item_t it;
    it.op    = op;
    it.temp  = temp[7:0];
    it.sok   = sok;
    it.needs = needs;
    it.mode  = mode;
    it.conv  = conv;
    it.req   = req[14:0];
    it.outc  = outc[14:0];
    it.prev  = prev[14:0];
    it.gear  = gear[14:0];
    return it;
  endfunction

  function automatic limit_result_t mk_res(int limit, bit stp, bit lim, bit blk,
                                           bit lv, bit shut, bit sf);
    limit_result_t r;
    r.limit       = limit[14:0];
    r.step_down   = stp;
    r.limiter     = lim;
    r.turbo_blk   = blk;
    r.turbo_leave = lv;
    r.overheat    = shut;
    r.sfault      = sf;
    return r;
  endfunction

  task automatic add_row(tick_item_t it, logic typed, limit_result_t want);
    dir_row_t row;
    row.item  = it;
    row.typed = typed;
    row.want  = want;
    dir_rows.push_back(row);
  endtask

  // Offer one item and hold it until the transfer; a typed row overrides the
  // predicted result while the predictor still advances its state.
  task automatic send_item(tick_item_t it, logic typed, limit_result_t typed_want);
    limit_result_t want;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid          <= 1'b1;
    operation         <= it.op;
    temperature       <= it.temp;
    sensor_ok         <= it.sok;
    needs_stepdown    <= it.needs;
    mode_class        <= it.mode;
    converter_on      <= it.conv;
    requested_current <= it.req;
    output_current    <= it.outc;
    previous_current  <= it.prev;
    new_gear_current  <= it.gear;
    do @(posedge clk); while (!in_ready);
    want = predict_limit(it);
    if (typed) want = typed_want;
    limits_due.push_back(want);
  endtask

  // Drop valid and wait until every expected result has come back.
  task automatic drain_results();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (limits_due.size() != 0 && guard < DRAIN_GUARD) begin
      @(posedge clk);
      guard++;
    end
  endtask

  task automatic write_reg(logic [2:0] idx, int val);
    logic [14:0] d;
    d = val[14:0];
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    case (idx)
      REG_TARGET_TEMP:       tgt_norm  = $signed(d[7:0]);
      REG_TURBO_TARGET_TEMP: tgt_turbo = $signed(d[7:0]);
      REG_RELEASE_TEMP:      rel_t     = $signed(d[7:0]);
      REG_TURBO_OFF_TEMP:    off_t     = $signed(d[7:0]);
      REG_SHUTDOWN_TEMP:     shut_t    = $signed(d[7:0]);
      REG_MIN_CURRENT:       min_c     = d;
      REG_TURBO_CURRENT:     turbo_c   = d;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Reprogram all registers with the block idle.
  task automatic apply_settings(int tt, int ttb, int rl, int off, int sh,
                                int mn, int tc);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(REG_TARGET_TEMP, tt);
    write_reg(REG_TURBO_TARGET_TEMP, ttb);
    write_reg(REG_RELEASE_TEMP, rl);
    write_reg(REG_TURBO_OFF_TEMP, off);
    write_reg(REG_SHUTDOWN_TEMP, sh);
    write_reg(REG_MIN_CURRENT, mn);
    write_reg(REG_TURBO_CURRENT, tc);
    cfg_we <= 1'b0;
  endtask

  // Temperature mostly walks slowly so the hysteresis and the PI loop see
  // realistic trajectories; some jumps land near a threshold.
  task automatic make_random_item(output tick_item_t it);
    int pick, near, t;
    pick = $urandom_range(0, 19);
    if (pick < 12) begin
      walk_temp = clamp_temp(walk_temp + int'($urandom_range(0, 6)) - 3);
    end else if (pick < 17) begin
      case ($urandom_range(0, 8))
        0: near = tgt_norm;
        1: near = tgt_turbo;
        2: near = rel_t;
        3: near = off_t;
        4: near = shut_t;
        5: near = off_t - FLAG_BAND;
        6: near = shut_t - FLAG_BAND;
        7: near = tgt_norm - FLAG_BAND;
        default: near = off_t - HOT_MARGIN_C;
      endcase
      walk_temp = clamp_temp(near + int'($urandom_range(0, 6)) - 3);
    end else begin
      walk_temp = int'($urandom_range(0, 255)) - 128;
    end
    t = walk_temp;
    it = mk_item(($urandom_range(0, 9) == 0) ? OP_GEAR : OP_TICK, t,
                 $urandom_range(0, 11) != 0, $urandom_range(0, 7) != 0,
                 2'($urandom_range(0, 3)), $urandom_range(0, 5) != 0,
                 ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3000)
                                             : $urandom_range(0, 32767),
                 $urandom_range(0, 32767), $urandom_range(0, 32767),
                 $urandom_range(0, 32767));
  endtask

  // Receiver: random stall bursts, calm stretches, and the long hold-off
  // that backs the block up into its input.
  initial begin : receiver
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (holdoff_req != holdoff_done) begin
        out_ready <= 1'b0;
        repeat (RX_HOLDOFF_CYCLES) @(posedge clk);
        holdoff_done++;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(0, 8)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 30) == 0) repeat (40) @(posedge clk);
      end
    end
  end

  // Compare every result transfer with the oldest expectation.
  always @(posedge clk) begin : result_check
    limit_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (limits_due.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing expected",
                                  result_idx));
      end else begin
        want = limits_due.pop_front();
        check_field("current_limit", current_limit, want.limit);
        check_field("step_down_active", step_down_active, want.step_down);
        check_field("limiter_enabled", limiter_enabled, want.limiter);
        check_field("turbo_disabled", turbo_disabled, want.turbo_blk);
        check_field("leave_turbo", leave_turbo, want.turbo_leave);
        check_field("overheat_fault", overheat_fault, want.overheat);
        check_field("sensor_fault", sensor_fault, want.sfault);
      end
      result_idx++;
    end
  end

  // Hard stop in case the handshake hangs.
  initial begin : watchdog
    #(LIMIT_NS);
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    tick_item_t it;
    int base, tt, ttb, off, sh;
    // Directed table, run from reset with the default settings. Typed
    // expectations only where the answer is obvious.
    // cold tick: limiter stays off, limit passes the request through
    add_row(mk_item(OP_TICK, 25, 1, 1, MODE_ORDINARY, 1, 1000, 500, 0, 0),
            1'b1, mk_res(1000, 0, 0, 0, 0, 0, 0));
    // gear change on an unlimited gear: zero limit, stored flags
    add_row(mk_item(OP_GEAR, 25, 1, 0, MODE_ORDINARY, 1, 1000, 0, 100, 9000),
            1'b1, mk_res(0, 0, 0, 0, 0, 0, 0));
    // sensor fault at the coldest reading, full request
    add_row(mk_item(OP_TICK, -128, 0, 1, MODE_ORDINARY, 1, 32767, 0, 0, 0),
            1'b1, mk_res(32767, 0, 0, 0, 0, 0, 1));
    // hottest reading at full current: every trigger fires
    add_row(mk_item(OP_TICK, 127, 1, 1, MODE_ORDINARY, 1, 32767, 32767, 0, 0),
            1'b0, '0);
    // rebase with equal currents: zero limit, all stored flags high
    add_row(mk_item(OP_GEAR, 127, 1, 1, MODE_ORDINARY, 1, 0, 0, 0, 0),
            1'b1, mk_res(0, 1, 1, 1, 1, 1, 0));
    // strobe runs the loop without the converter
    add_row(mk_item(OP_TICK, 60, 1, 1, MODE_FLASH, 0, 20000, 0, 0, 0), 1'b0, '0);
    add_row(mk_item(OP_TICK, 65, 1, 1, MODE_BOOST, 1, 20000, 12000, 0, 0), 1'b0, '0);
    // unused mode code behaves as ordinary, cooling under the hold-off
    add_row(mk_item(OP_TICK, 50, 1, 1, MODE_SPARE, 1, 20000, 3000, 0, 0), 1'b0, '0);
    add_row(mk_item(OP_TICK, 50, 1, 1, MODE_ORDINARY, 0, 20000, 3000, 0, 0), 1'b0, '0);
    add_row(mk_item(OP_TICK, -128, 1, 1, MODE_ORDINARY, 1, 15000, 0, 0, 0), 1'b0, '0);
    // gear not under thermal control forces the limiter off
    add_row(mk_item(OP_TICK, 90, 1, 0, MODE_ORDINARY, 1, 32767, 32767, 0, 0), 1'b0, '0);
    // zero request under a hot limiter: floor at min_current
    add_row(mk_item(OP_TICK, 127, 1, 1, MODE_ORDINARY, 1, 0, 0, 0, 0), 1'b0, '0);
    // rebases: new gear below the old one, then far above
    add_row(mk_item(OP_GEAR, 127, 1, 1, MODE_ORDINARY, 1, 0, 0, 32767, 0), 1'b0, '0);
    add_row(mk_item(OP_GEAR, 127, 1, 1, MODE_BOOST, 1, 0, 0, 0, 32767), 1'b0, '0);
    // offset bound clamp in turbo
    add_row(mk_item(OP_TICK, 127, 1, 1, MODE_BOOST, 1, 32767, 32767, 0, 0), 1'b0, '0);
    // sensor fault with the limiter engaged
    add_row(mk_item(OP_TICK, 0, 0, 1, MODE_ORDINARY, 1, 25000, 100, 0, 0), 1'b0, '0);
    // errors inside the dead band on both sides
    add_row(mk_item(OP_TICK, 56, 1, 1, MODE_ORDINARY, 1, 25000, 4600, 0, 0), 1'b0, '0);
    add_row(mk_item(OP_TICK, 54, 1, 1, MODE_ORDINARY, 1, 25000, 4600, 0, 0), 1'b0, '0);
    // unused mode code without converter: loop skipped, unlike strobe
    add_row(mk_item(OP_TICK, 127, 1, 1, MODE_SPARE, 0, 18000, 9000, 0, 0), 1'b0, '0);
    add_row(mk_item(OP_TICK, 40, 1, 1, MODE_FLASH, 0, 18000, 9000, 0, 0), 1'b0, '0);

    // hold reset, then release
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[k]) send_item(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].want);

    for (int p = 0; p < NUM_PHASES; p++) begin
      // pick ordered thresholds for the realistic phases
      base = int'($urandom_range(0, 80)) - 40;
      tt   = base + int'($urandom_range(2, 12));
      ttb  = tt + int'($urandom_range(0, 8));
      off  = ttb + int'($urandom_range(2, 15));
      sh   = off + int'($urandom_range(2, 15));
      case (p)
        0: ;  // keep the reset settings
        1: apply_settings(-128, -128, -128, -128, -128, 0, 32767);
        2: apply_settings(127, 127, 127, 127, 127, 32767, 0);
        3, 6: apply_settings(tt, ttb, base, off, sh, $urandom_range(0, 2000),
                             $urandom_range(5000, 32767));
        4: apply_settings(tt, ttb, base, off, sh, $urandom_range(5000, 9000),
                          $urandom_range(0, 4999));
        5: apply_settings(int'($urandom_range(0, 255)) - 128,
                          int'($urandom_range(0, 255)) - 128,
                          int'($urandom_range(0, 255)) - 128,
                          int'($urandom_range(0, 255)) - 128,
                          int'($urandom_range(0, 255)) - 128,
                          $urandom_range(0, 32767), $urandom_range(0, 32767));
        default: apply_settings(RST_TARGET_TEMP, RST_TURBO_TARGET_TEMP,
                                RST_RELEASE_TEMP, RST_TURBO_OFF_TEMP,
                                RST_SHUTDOWN_TEMP, RST_MIN_CURRENT,
                                RST_TURBO_CURRENT);
      endcase
      walk_temp = rel_t;
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        // long receiver hold-off while items keep coming
        if (p == 3 && n == 60) holdoff_req++;
        // sender pause until the block has drained
        if (p == 6 && n == 120) drain_results();
        // last stretch of the run: no idling on either side
        if (p == NUM_PHASES - 1 && n == 90) quiet = 1'b1;
        make_random_item(it);
        send_item(it, 1'b0, '0);
      end
    end

    drain_results();
    if (limits_due.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", limits_due.size()));
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
